### rtl/uitf_pkg.sv
// Package: item types, character codes and the sequencer microcode table.
`default_nettype none
package uitf_pkg;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  radix_mode;
        logic        zero_fill;
        logic        left_justify;
        logic        alt_prefix;
        logic [6:0]  field_width;
        logic [5:0]  min_digits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_item_t;

    localparam logic [1:0] MODE_HEX_LO = 2'd1;
    localparam logic [1:0] MODE_HEX_UP = 2'd2;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_X_LO  = 8'h78;
    localparam logic [7:0] CHR_X_UP  = 8'h58;
    localparam logic [7:0] CHR_A_LO  = 8'h61;
    localparam logic [7:0] CHR_A_UP  = 8'h41;

    localparam int         NUM_DIGITS = 20;
    localparam logic [6:0] MAX_CHARS  = 7'd64;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_CONV,
        OP_COUNT,
        OP_SIZE,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        CH_SPACE,
        CH_ZERO,
        CH_X,
        CH_DIGIT
    } chr_sel_t;

    typedef enum logic [2:0] {
        CNT_NONE,
        CNT_LPAD,
        CNT_PFX,
        CNT_ZPAD,
        CNT_PREC,
        CNT_NDIG,
        CNT_RPAD
    } cnt_sel_t;

    typedef struct packed {
        op_t        op;
        chr_sel_t   chr;
        cnt_sel_t   cnt;
        logic [3:0] next;
        logic [3:0] jump;
    } ucode_t;

    localparam logic [3:0] STEP_WAIT   = 4'd0;
    localparam logic [3:0] STEP_CONV   = 4'd1;
    localparam logic [3:0] STEP_COUNT  = 4'd2;
    localparam logic [3:0] STEP_SIZE   = 4'd3;
    localparam logic [3:0] STEP_LSPACE = 4'd4;
    localparam logic [3:0] STEP_PFX0   = 4'd5;
    localparam logic [3:0] STEP_PFXX   = 4'd6;
    localparam logic [3:0] STEP_ZPAD   = 4'd7;
    localparam logic [3:0] STEP_PREC   = 4'd8;
    localparam logic [3:0] STEP_DIGITS = 4'd9;
    localparam logic [3:0] STEP_RSPACE = 4'd10;

    function automatic ucode_t ucode_rom(input logic [3:0] step);
        ucode_t w;
        unique case (step)
            STEP_WAIT:   w = '{OP_WAIT,  CH_SPACE, CNT_NONE, STEP_CONV,   STEP_COUNT};
            STEP_CONV:   w = '{OP_CONV,  CH_SPACE, CNT_NONE, STEP_COUNT,  STEP_WAIT};
            STEP_COUNT:  w = '{OP_COUNT, CH_SPACE, CNT_NONE, STEP_SIZE,   STEP_WAIT};
            STEP_SIZE:   w = '{OP_SIZE,  CH_SPACE, CNT_NONE, STEP_LSPACE, STEP_WAIT};
            STEP_LSPACE: w = '{OP_EMIT,  CH_SPACE, CNT_LPAD, STEP_PFX0,   STEP_WAIT};
            STEP_PFX0:   w = '{OP_EMIT,  CH_ZERO,  CNT_PFX,  STEP_PFXX,   STEP_WAIT};
            STEP_PFXX:   w = '{OP_EMIT,  CH_X,     CNT_PFX,  STEP_ZPAD,   STEP_WAIT};
            STEP_ZPAD:   w = '{OP_EMIT,  CH_ZERO,  CNT_ZPAD, STEP_PREC,   STEP_WAIT};
            STEP_PREC:   w = '{OP_EMIT,  CH_ZERO,  CNT_PREC, STEP_DIGITS, STEP_WAIT};
            STEP_DIGITS: w = '{OP_EMIT,  CH_DIGIT, CNT_NDIG, STEP_RSPACE, STEP_WAIT};
            STEP_RSPACE: w = '{OP_EMIT,  CH_SPACE, CNT_RPAD, STEP_WAIT,   STEP_WAIT};
            default:     w = '{OP_WAIT,  CH_SPACE, CNT_NONE, STEP_CONV,   STEP_COUNT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/unsigned_integer_text_formatter.sv
// Top level: printf-style unsigned decimal/hex formatter, one character per item.
//
// Input channel s_*: one item per number to format (value plus format options).
// Output channel m_*: the formatted field, one ASCII character per item,
// with last set on the final character; a field has 1 to 64 characters.
// A microcode table steps a small datapath: wait, binary-to-BCD conversion,
// two sizing steps, then seven emit steps (left spaces, "0", "x", zero fill,
// precision zeros, digits, right spaces).
// Decimal conversion is a double-dabble loop taking 2 bits a cycle over the
// whole 64-bit value; hex skips it. An item passes through the wait step,
// the conversion (decimal only), the two sizing steps and all seven emit
// steps; an emit step with no characters to send is still passed through.
// The first character follows the sizing steps and any empty emit steps
// before it. s_ready is high only in the wait step; the
// next item may enter while the final character still sits in the output
// register. When m_ready is low the output register holds its item and the
// sequencer pauses on the current character. Synchronous reset returns the
// sequencer to the wait step and drops m_valid.
`default_nettype none
module unsigned_integer_text_formatter (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire uitf_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output uitf_pkg::out_item_t      m_data
);

    logic [3:0]               step_reg,    step_next;
    logic [6:0]               pos_reg,     pos_next;
    logic [6:0]               emitted_reg, emitted_next;
    logic [4:0]               iter_reg,    iter_next;
    logic [63:0]              bin_reg,     bin_next;
    logic [19:0][3:0]         bcd_reg,     bcd_next;
    uitf_pkg::in_item_t       item_reg,    item_next;
    logic [4:0]               ndig_reg,    ndig_next;
    logic [5:0]               lprec_reg,   lprec_next;
    logic [6:0]               pad_reg,     pad_next;
    logic [6:0]               total_reg,   total_next;
    logic                     m_valid_reg, m_valid_next;
    uitf_pkg::out_item_t      m_data_reg,  m_data_next;

    uitf_pkg::ucode_t uc;
    logic             is_hex;
    logic             in_hex;
    logic             upper;
    logic             prefix;
    logic [6:0]       count;
    logic [7:0]       chr;
    logic [4:0]       dig_idx;
    logic [3:0]       dig;
    logic             out_free;
    logic             can_emit;
    logic             go;
    logic [4:0]       nd;
    logic [5:0]       lp;
    logic [6:0]       occ;
    logic [6:0]       longest;

    function automatic logic [79:0] dd_step(input logic [79:0] bcd, input logic b);
        logic [79:0] t;
        t = bcd;
        for (int i = 0; i < uitf_pkg::NUM_DIGITS; i++) begin
            if (t[i*4 +: 4] >= 4'd5) begin
                t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
            end
        end
        return {t[78:0], b};
    endfunction

    always_comb begin
        uc     = uitf_pkg::ucode_rom(step_reg);
        is_hex = (item_reg.radix_mode == uitf_pkg::MODE_HEX_LO) ||
                 (item_reg.radix_mode == uitf_pkg::MODE_HEX_UP);
        in_hex = (s_data.radix_mode == uitf_pkg::MODE_HEX_LO) ||
                 (s_data.radix_mode == uitf_pkg::MODE_HEX_UP);
        upper  = (item_reg.radix_mode == uitf_pkg::MODE_HEX_UP);
        prefix = item_reg.alt_prefix && is_hex;

        case (uc.cnt)
            uitf_pkg::CNT_LPAD:
                count = (!item_reg.zero_fill && !item_reg.left_justify) ? pad_reg : 7'd0;
            uitf_pkg::CNT_PFX:  count = prefix ? 7'd1 : 7'd0;
            uitf_pkg::CNT_ZPAD:
                count = (item_reg.zero_fill && !item_reg.left_justify) ? pad_reg : 7'd0;
            uitf_pkg::CNT_PREC: count = {1'b0, lprec_reg};
            uitf_pkg::CNT_NDIG: count = {2'b00, ndig_reg};
            uitf_pkg::CNT_RPAD: count = item_reg.left_justify ? pad_reg : 7'd0;
            default:            count = 7'd0;
        endcase

        dig_idx = ndig_reg - pos_reg[4:0] - 5'd1;
        dig     = bcd_reg[dig_idx];

        case (uc.chr)
            uitf_pkg::CH_ZERO: chr = uitf_pkg::CHR_ZERO;
            uitf_pkg::CH_X:    chr = upper ? uitf_pkg::CHR_X_UP : uitf_pkg::CHR_X_LO;
            uitf_pkg::CH_DIGIT: begin
                if (dig < 4'd10) begin
                    chr = uitf_pkg::CHR_ZERO + {4'b0000, dig};
                end else begin
                    chr = (upper ? uitf_pkg::CHR_A_UP : uitf_pkg::CHR_A_LO)
                          + {4'b0000, dig} - 8'd10;
                end
            end
            default:           chr = uitf_pkg::CHR_SPACE;
        endcase

        out_free = !m_valid_reg || m_ready;
        can_emit = (pos_reg < count) && (emitted_reg < total_reg);
        go       = (uc.op == uitf_pkg::OP_EMIT) && can_emit && out_free;

        nd = 5'd1;
        for (int i = 0; i < uitf_pkg::NUM_DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                nd = 5'(i + 1);
            end
        end

        lp      = (item_reg.min_digits > {1'b0, ndig_reg}) ?
                  item_reg.min_digits - {1'b0, ndig_reg} : 6'd0;
        occ     = {2'b00, ndig_reg} + {1'b0, lp} + (prefix ? 7'd2 : 7'd0);
        longest = (item_reg.field_width > occ) ? item_reg.field_width : occ;

        step_next    = step_reg;
        pos_next     = pos_reg;
        emitted_next = emitted_reg;
        iter_next    = iter_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        item_next    = item_reg;
        ndig_next    = ndig_reg;
        lprec_next   = lprec_reg;
        pad_next     = pad_reg;
        total_next   = total_reg;
        s_ready      = 1'b0;

        unique case (uc.op)
            uitf_pkg::OP_WAIT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next    = s_data;
                    bin_next     = s_data.value;
                    bcd_next     = in_hex ? {16'h0000, s_data.value} : '0;
                    iter_next    = 5'd0;
                    emitted_next = 7'd0;
                    pos_next     = 7'd0;
                    step_next    = in_hex ? uc.jump : uc.next;
                end
            end
            uitf_pkg::OP_CONV: begin
                bcd_next  = dd_step(dd_step(bcd_reg, bin_reg[63]), bin_reg[62]);
                bin_next  = {bin_reg[61:0], 2'b00};
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'd31) begin
                    step_next = uc.next;
                end
            end
            uitf_pkg::OP_COUNT: begin
                ndig_next = nd;
                step_next = uc.next;
            end
            uitf_pkg::OP_SIZE: begin
                lprec_next = lp;
                pad_next   = (item_reg.field_width > occ) ? item_reg.field_width - occ : 7'd0;
                total_next = (longest > uitf_pkg::MAX_CHARS) ? uitf_pkg::MAX_CHARS : longest;
                step_next  = uc.next;
            end
            uitf_pkg::OP_EMIT: begin
                if (!can_emit) begin
                    pos_next  = 7'd0;
                    step_next = uc.next;
                end else if (go) begin
                    emitted_next = emitted_reg + 7'd1;
                    if ((pos_reg + 7'd1 == count) || (emitted_reg + 7'd1 == total_reg)) begin
                        pos_next  = 7'd0;
                        step_next = uc.next;
                    end else begin
                        pos_next = pos_reg + 7'd1;
                    end
                end
            end
            default: begin
                step_next = uitf_pkg::STEP_WAIT;
            end
        endcase

        m_data_next = m_data_reg;
        if (go) begin
            m_valid_next         = 1'b1;
            m_data_next.out_char = chr;
            m_data_next.last     = (emitted_reg + 7'd1 == total_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= uitf_pkg::STEP_WAIT;
            pos_reg     <= 7'd0;
            emitted_reg <= 7'd0;
            iter_reg    <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            pos_reg     <= pos_next;
            emitted_reg <= emitted_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        item_reg   <= item_next;
        ndig_reg   <= ndig_next;
        lprec_reg  <= lprec_next;
        pad_reg    <= pad_next;
        total_reg  <= total_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

### rtl/uitf_checker.sv
// Port-level checker for the formatter, bound to the top level.
`default_nettype none
module uitf_props (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire uitf_pkg::in_item_t  s_data,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire uitf_pkg::out_item_t m_data
);

    logic [1:0] pend_reg, pend_next;
    logic [5:0] len_reg,  len_next;
    logic       s_acc;
    logic       m_acc;

    always_comb begin
        s_acc     = s_valid && s_ready;
        m_acc     = m_valid && m_ready;
        pend_next = pend_reg + (s_acc ? 2'd1 : 2'd0) - ((m_acc && m_data.last) ? 2'd1 : 2'd0);
        len_next  = len_reg;
        if (m_acc) begin
            len_next = m_data.last ? 6'd0 : len_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
            len_reg  <= 6'd0;
        end else begin
            pend_reg <= pend_next;
            len_reg  <= len_next;
        end
    end

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output item changed");

    // every character belongs to an accepted item
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("output item without input item");

    // a field never runs past 64 characters
    a_max_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && len_reg == 6'd63 |-> m_data.last)
        else $error("field longer than 64 characters");

endmodule

bind unsigned_integer_text_formatter uitf_props u_uitf_props (.*);
`default_nettype wire
